/* rtl/core/ntp_pkg.sv */
// shared types, constants and the octave period table for the note to period block
`default_nettype none
package ntp_pkg;

	localparam int unsigned ToneW   = 16;
	localparam int unsigned NoteW   = 8;
	localparam int unsigned RateW   = 16;
	localparam int unsigned PeriodW = 16;
	localparam int unsigned FineW   = 7;
	localparam int unsigned PosW    = 4;   // position inside the octave, 0..11
	localparam int unsigned OctW    = 7;   // signed octave offset, -43..21
	localparam int unsigned OffW    = 10;  // offset semitone distance, 5..771
	localparam int unsigned QuoW    = 7;   // offset octave number, 0..64
	localparam int unsigned TabW    = 16;
	localparam int unsigned LoHiW   = 14;
	localparam int unsigned BlendW  = 22;
	localparam int unsigned NormW   = 15;

	// diff + DiffOffset is never negative; DiffOffset is a multiple of 12
	localparam logic signed [10:0] DiffOffset = 11'sd516;
	localparam logic [7:0]         OffOctaves = 8'd43;
	localparam logic [8:0]         Recip3     = 9'd171;  // 171/512 ~ 1/3
	localparam logic [PosW-1:0]    PosMax     = 4'd11;
	localparam logic [PosW-1:0]    PosTop     = 4'd12;
	localparam logic [7:0]         FineOne    = 8'h80;
	localparam logic [PeriodW-1:0] PeriodMin  = 16'd124;

	typedef struct packed {
		logic [FineW-1:0]       fine;
		logic [PosW-1:0]        pos;
		logic signed [OctW-1:0] oct;
		logic [RateW-1:0]       rate;
	} ntp_cls_t;

	function automatic logic [TabW-1:0] oct_period(input logic [PosW-1:0] idx);
		logic [TabW-1:0] v;
		case (idx)
			4'd0:    v = 16'h4000;
			4'd1:    v = 16'h43CE;
			4'd2:    v = 16'h47D7;
			4'd3:    v = 16'h4C1B;
			4'd4:    v = 16'h50A2;
			4'd5:    v = 16'h556D;
			4'd6:    v = 16'h5A82;
			4'd7:    v = 16'h5FE4;
			4'd8:    v = 16'h6598;
			4'd9:    v = 16'h6BA2;
			4'd10:   v = 16'h7209;
			4'd11:   v = 16'h78D0;
			4'd12:   v = 16'h8000;
			default: v = 16'h8000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/ntp_front.sv */
// front end: accepts pitch requests and splits them into octave and position
`default_nettype none
module ntp_front
	import ntp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ToneW-1:0]     tone,
	input  wire logic [NoteW-1:0]     base_note,
	input  wire logic [RateW-1:0]     sample_rate,
	output logic                      cls_valid,
	input  wire logic                 cls_ready,
	output ntp_cls_t                  cls
);

	logic                   valid_s1, valid_s2;
	logic                   ready_s2;
	logic [OffW-1:0]        off_s1, off_s2;
	logic [FineW-1:0]       fine_s1, fine_s2;
	logic [RateW-1:0]       rate_s1, rate_s2;
	logic [QuoW-1:0]        quo_s2;

	logic signed [10:0]     diff;
	logic signed [10:0]     off_full;
	logic [15:0]            quo_prod;
	logic [OffW-1:0]        twelve_q;

	assign ready_s2 = !valid_s2 || cls_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// coarse semitone is the arithmetic shift of tone by 7
	assign diff     = 11'($signed(tone[ToneW-1:FineW])) - $signed({3'b000, base_note});
	assign off_full = diff + DiffOffset;

	// off/12 as (off/4)/3 with a reciprocal multiply, exact for off/4 up to 192
	assign quo_prod = 16'(off_s1[OffW-1:2] * Recip3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			off_s1  <= off_full[OffW-1:0];
			fine_s1 <= tone[FineW-1:0];
			rate_s1 <= sample_rate;
		end
		if (ready_s2 && valid_s1) begin
			off_s2  <= off_s1;
			fine_s2 <= fine_s1;
			rate_s2 <= rate_s1;
			quo_s2  <= quo_prod[15:9];
		end
	end

	assign twelve_q = {quo_s2, 3'b000} + {1'b0, quo_s2, 2'b00};

	always_comb begin
		cls.fine  = fine_s2;
		cls.rate  = rate_s2;
		cls.oct   = OctW'({1'b0, quo_s2} - OffOctaves);
		cls.pos   = PosW'(off_s2 - twelve_q);
	end

	assign cls_valid = valid_s2;

endmodule
`default_nettype wire

/* rtl/core/ntp_queue.sv */
// two-entry queue between the front and back ends
`default_nettype none
module ntp_queue
	import ntp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  ntp_cls_t       push_data,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output ntp_cls_t       pop_data
);

	ntp_cls_t   entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* rtl/core/ntp_back.sv */
// back end: rate scaling, table interpolation and period clamping
`default_nettype none
module ntp_back
	import ntp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cls_valid,
	output logic                     cls_ready,
	input  ntp_cls_t                 cls,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [PeriodW-1:0]       period
);

	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   ready_s2, ready_s3, ready_s4;
	logic [RateW-1:0]       rate_s1;
	logic [TabW-1:0]        tlo_s1, thi_s1;
	logic [FineW-1:0]       fine_s1, fine_s2;
	logic [LoHiW-1:0]       lo_s2, hi_s2;
	logic [NormW-1:0]       p_s3;
	logic [PeriodW-1:0]     period_s4;

	logic [RateW-1:0]       rate_x8;
	logic [RateW-1:0]       rate_sc;
	logic [OctW-1:0]        oct_neg;
	logic [PosW-1:0]        pos_c;
	logic [31:0]            lo_prod, hi_prod;
	logic [BlendW-1:0]      blend;
	logic [PeriodW-1:0]     norm;

	assign ready_s4  = !valid_s4 || out_ready;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign cls_ready = !valid_s1 || ready_s2;

	// octave shift of the rate word, zero once the shift reaches 16
	always_comb begin
		rate_x8 = {cls.rate[RateW-4:0], 3'b000};
		oct_neg = OctW'(-cls.oct);
		rate_sc = rate_x8;
		if (!cls.oct[OctW-1] && cls.oct != '0) begin
			if (cls.oct[OctW-2:4] == '0)
				rate_sc = rate_x8 >> cls.oct[3:0];
			else
				rate_sc = '0;
		end else if (cls.oct[OctW-1]) begin
			if (oct_neg[OctW-1:4] == '0)
				rate_sc = rate_x8 << oct_neg[3:0];
			else
				rate_sc = '0;
		end
		pos_c = (cls.pos > PosMax) ? PosMax : cls.pos;
	end

	assign lo_prod = 32'(tlo_s1) * 32'(rate_s1);
	assign hi_prod = 32'(thi_s1) * 32'(rate_s1);

	assign blend = BlendW'(lo_s2) * BlendW'(fine_s2)
		+ BlendW'(hi_s2) * BlendW'(FineOne - {1'b0, fine_s2});

	// short periods double until they reach the minimum; a zero period becomes the minimum
	always_comb begin
		norm = PeriodW'(p_s3);
		if (norm == '0)
			norm = PeriodMin;
		for (int i = 0; i < 7; i++) begin
			if (norm < PeriodMin)
				norm = {norm[PeriodW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (cls_ready)
				valid_s1 <= cls_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_ready && cls_valid) begin
			rate_s1 <= rate_sc;
			tlo_s1  <= oct_period(PosMax - pos_c);
			thi_s1  <= oct_period(PosTop - pos_c);
			fine_s1 <= cls.fine;
		end
		if (ready_s2 && valid_s1) begin
			lo_s2   <= lo_prod[31:18];
			hi_s2   <= hi_prod[31:18];
			fine_s2 <= fine_s1;
		end
		if (ready_s3 && valid_s2)
			p_s3 <= blend[NormW+6:7];
		if (ready_s4 && valid_s3)
			period_s4 <= norm;
	end

	assign out_valid = valid_s4;
	assign period    = period_s4;

endmodule
`default_nettype wire

/* rtl/core/note_pitch_to_sample_period.sv */
// Note pitch to sample playback period. Each transaction on the input carries a
// pitch in 1/128 semitones, the instrument's base note and its sample rate word,
// and yields one period transaction (124..32767). One request is taken per clock
// while the pipeline is not stalled. A request passes through two front stages
// (semitone split, divide by 12 through a reciprocal multiply), one slot of a
// two-entry queue, and four back stages (octave shift and table fetch, the two
// table-by-rate multiplies, the blend multiplies, the short-period doubling into
// the output register). Results come out in order.
`default_nettype none
module note_pitch_to_sample_period
	import ntp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ToneW-1:0]    tone,
	input  wire logic [NoteW-1:0]    base_note,
	input  wire logic [RateW-1:0]    sample_rate,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [PeriodW-1:0]       period
);

	ntp_cls_t front_cls, back_cls;
	logic     front_valid, front_ready;
	logic     back_valid, back_ready;

	ntp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tone        (tone),
		.base_note   (base_note),
		.sample_rate (sample_rate),
		.cls_valid   (front_valid),
		.cls_ready   (front_ready),
		.cls         (front_cls)
	);

	ntp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cls),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cls)
	);

	ntp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (back_valid),
		.cls_ready (back_ready),
		.cls       (back_cls),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.period    (period)
	);

endmodule
`default_nettype wire
